[sv/bdm_pkg.sv]
package bdm_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned TickW    = 16;
	localparam int unsigned FlagsW   = 5;
	localparam int unsigned MaskW    = 13;
	localparam int unsigned CodeW    = 4;
	localparam int unsigned ClickW   = 4;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BUTTON_TYPE,
		REG_BUTTON_FLAGS,
		REG_TRIGGER_MASK,
		REG_HOLD_TICKS,
		REG_MULTICLICK_TICKS,
		REG_CFG_PRESS_TICKS,
		REG_SILENT_TICKS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_STATE,
		EV_ACTION,
		EV_RELAY,
		EV_CONFIG
	} ev_kind_t;

	// button_flags bit positions
	localparam int unsigned FLAG_PULLUP     = 0;
	localparam int unsigned FLAG_CFG_BUTTON = 1;
	localparam int unsigned FLAG_CFG_TOGGLE = 2;
	localparam int unsigned FLAG_RELAY      = 3;
	localparam int unsigned FLAG_CHANNEL    = 4;

	localparam logic [CodeW-1:0] ACT_ON          = 4'd0;
	localparam logic [CodeW-1:0] ACT_OFF         = 4'd1;
	localparam logic [CodeW-1:0] ACT_HOLD        = 4'd2;
	localparam logic [CodeW-1:0] ACT_PRESS_BASE  = 4'd2;
	localparam logic [CodeW-1:0] ACT_TOGGLE_BASE = 4'd7;
	localparam logic [CodeW-1:0] ACT_NONE        = 4'd0;

	localparam logic [TickW-1:0]  HOLD_TICKS_DEF  = 16'd100;
	localparam logic [TickW-1:0]  MC_TICKS_DEF    = 16'd30;
	localparam logic [TickW-1:0]  CFG_PRESS_DEF   = 16'd500;
	localparam logic [TickW-1:0]  SILENT_DEF      = 16'd40;
	localparam logic [TickW-1:0]  TICK_MAX        = 16'hFFFF;
	localparam logic [ClickW-1:0] CLICK_MAX       = 4'd15;
	localparam logic [ClickW-1:0] CLICK_MAPPED_MAX = 4'd5;

	typedef struct packed {
		ev_kind_t         kind;
		logic             state;
		logic [CodeW-1:0] code;
	} ev_t;

	// debounce outcome for the current tick
	typedef struct packed {
		logic done;
		logic level;
	} db_res_t;

	function automatic ev_t make_ev(ev_kind_t k, logic s, logic [CodeW-1:0] c);
		ev_t e;
		e.kind  = k;
		e.state = s;
		e.code  = c;
		return e;
	endfunction

endpackage

[sv/bdm_if.sv]
interface bdm_sample_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface bdm_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic       event_state;
	logic [3:0] action_code;
	logic       last_event;

	modport source (output valid, output event_kind, output event_state, output action_code,
		output last_event, input ready);
	modport sink (input valid, input event_kind, input event_state, input action_code,
		input last_event, output ready);
endinterface

[sv/button_debounce_multiclick.sv]
// pipeline: a sample beat enters the input register, is processed into the event group
//   register, and its event beats are presented from there
// throughput: one sample beat per cycle while events drain; a tick that yields up to 3
//   events holds the event register until all are taken; the event side sets the rate
// reset: arst_n clears configuration to its defaults, debounce, click and timer state
module button_debounce_multiclick #(
	parameter int unsigned STABLE_TICKS    = 4,
	parameter int unsigned CFG_CLICK_COUNT = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bdm_pkg::CfgDataW-1:0]  cfg_wdata,
	bdm_sample_if.sink                    sample_ch,
	bdm_event_if.source                   event_ch
);

	localparam logic [bdm_pkg::ClickW-1:0] CfgClicks = bdm_pkg::ClickW'(CFG_CLICK_COUNT);
	localparam logic [bdm_pkg::ClickW-1:0] ClickOne  = bdm_pkg::ClickW'(1);

	// configuration
	logic                         btype_q;
	logic [bdm_pkg::FlagsW-1:0]   flags_q;
	logic [bdm_pkg::MaskW-1:0]    mask_q;
	logic [bdm_pkg::TickW-1:0]    hold_q, mc_q, cfgp_q, silent_q;

	// click state
	logic                         reported_q, rep_d;
	logic [bdm_pkg::ClickW-1:0]   click_q, click_d;
	logic                         locked_q, locked_d;
	logic [bdm_pkg::TickW-1:0]    elapsed_q, elapsed_d;
	logic                         timer_q, timer_d;
	logic [bdm_pkg::TickW-1:0]    startup_q;

	// input register
	logic                         valid_s1;
	logic                         raw_s1;

	// event group register
	bdm_pkg::ev_t                 ev_q [3];
	logic [1:0]                   ev_cnt_q, ev_idx_q;

	bdm_pkg::db_res_t             db;
	bdm_pkg::ev_t                 cand [3];
	logic [2:0]                   cand_en;
	bdm_pkg::ev_t                 slot [3];
	logic [1:0]                   new_cnt;

	logic                         out_valid, ev_last, take, comp_fire;
	logic                         hold_cfg, cfg_clicks;
	logic [2:0]                   top_n;
	logic [bdm_pkg::ClickW-1:0]   lim, click_inc, cl;
	logic [bdm_pkg::CodeW-1:0]    click_code, onoff_code;
	logic [bdm_pkg::TickW-1:0]    d;
	logic                         changed;

	assign out_valid = (ev_cnt_q != 2'd0);
	assign ev_last   = (ev_idx_q == ev_cnt_q - 2'd1);
	assign take      = out_valid && event_ch.ready;
	assign comp_fire = valid_s1 && (!out_valid || (take && ev_last));

	assign sample_ch.ready = !valid_s1 || comp_fire;

	assign event_ch.valid       = out_valid;
	assign event_ch.event_kind  = ev_q[ev_idx_q].kind;
	assign event_ch.event_state = ev_q[ev_idx_q].state;
	assign event_ch.action_code = ev_q[ev_idx_q].code;
	assign event_ch.last_event  = ev_last;

	bdm_debounce #(
		.STABLE_TICKS(STABLE_TICKS)
	) u_debounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (comp_fire),
		.raw      (raw_s1),
		.act_level(!flags_q[bdm_pkg::FLAG_PULLUP]),
		.reported (reported_q),
		.res      (db)
	);

	// click limit from the highest enabled multiclick action, or the config click count
	always_comb begin
		hold_cfg   = flags_q[bdm_pkg::FLAG_CFG_BUTTON] && !btype_q &&
			!flags_q[bdm_pkg::FLAG_CFG_TOGGLE];
		cfg_clicks = flags_q[bdm_pkg::FLAG_CFG_BUTTON] && !hold_cfg;
		top_n = 3'd0;
		for (int n = 1; n <= 5; n++) begin
			if (mask_q[2+n] || mask_q[7+n]) top_n = 3'(n);
		end
		lim = cfg_clicks ? CfgClicks : {1'b0, top_n};
		click_code = (btype_q ? bdm_pkg::ACT_TOGGLE_BASE : bdm_pkg::ACT_PRESS_BASE) + click_q;
		onoff_code = db.level ? bdm_pkg::ACT_ON : bdm_pkg::ACT_OFF;
		click_inc  = (click_q == bdm_pkg::CLICK_MAX) ? click_q : click_q + ClickOne;
		d = (elapsed_q == bdm_pkg::TICK_MAX) ? elapsed_q : elapsed_q + 16'd1;
	end

	always_comb begin
		rep_d     = reported_q;
		click_d   = click_q;
		locked_d  = locked_q;
		elapsed_d = elapsed_q;
		timer_d   = timer_q;
		changed   = 1'b0;
		cl        = click_q;
		cand_en   = 3'b000;
		cand[0]   = bdm_pkg::make_ev(bdm_pkg::EV_STATE, db.level, bdm_pkg::ACT_NONE);
		cand[1]   = bdm_pkg::make_ev(bdm_pkg::EV_ACTION, 1'b0, onoff_code);
		cand[2]   = bdm_pkg::make_ev(bdm_pkg::EV_CONFIG, 1'b0, bdm_pkg::ACT_NONE);

		if (db.done) begin
			if (startup_q < silent_q) begin
				// silent period: record only
				rep_d = db.level;
			end else if (reported_q != db.level) begin
				changed    = 1'b1;
				timer_d    = 1'b0;
				rep_d      = db.level;
				cand_en[0] = 1'b1;
				if (mask_q != '0) begin
					if (!locked_q && (db.level || btype_q)) begin
						click_d = click_inc;
						if (btype_q)
							cand_en[1] = mask_q[onoff_code] &&
								flags_q[bdm_pkg::FLAG_CHANNEL];
						if (cfg_clicks && click_inc >= CfgClicks) begin
							click_d    = '0;
							cand_en[2] = 1'b1;
						end
					end
					elapsed_d = '0;
					timer_d   = 1'b1;
				end
			end
		end

		if (!changed && timer_q) begin
			elapsed_d = d;
			if (!btype_q && rep_d && !locked_q) begin
				// held press: config request and hold action
				cand[0] = bdm_pkg::make_ev(bdm_pkg::EV_CONFIG, 1'b0, bdm_pkg::ACT_NONE);
				cand[1] = bdm_pkg::make_ev(bdm_pkg::EV_ACTION, 1'b0, bdm_pkg::ACT_HOLD);
				if (hold_cfg && d >= cfgp_q) begin
					timer_d    = 1'b0;
					cl         = '0;
					cand_en[0] = 1'b1;
				end
				if (cl == ClickOne && mask_q[bdm_pkg::ACT_HOLD] && d >= hold_q) begin
					cand_en[1] = flags_q[bdm_pkg::FLAG_CHANNEL];
					cl         = '0;
					if (!hold_cfg) timer_d = 1'b0;
				end
				click_d = cl;
			end
			if (!rep_d || btype_q) begin
				if (!locked_q && click_q == ClickOne && flags_q[bdm_pkg::FLAG_RELAY]) begin
					cand[2] = bdm_pkg::make_ev(bdm_pkg::EV_RELAY, 1'b0, bdm_pkg::ACT_NONE);
				end else begin
					cand[2] = bdm_pkg::make_ev(bdm_pkg::EV_ACTION, 1'b0, click_code);
				end
				if (d >= mc_q || (!locked_q && click_q >= lim)) begin
					if (!locked_q) begin
						if (click_q == ClickOne && flags_q[bdm_pkg::FLAG_RELAY])
							cand_en[2] = 1'b1;
						else if (click_q != '0 && click_q <= bdm_pkg::CLICK_MAPPED_MAX)
							cand_en[2] = mask_q[click_code] &&
								flags_q[bdm_pkg::FLAG_CHANNEL];
					end
					click_d = '0;
					if (d >= mc_q || lim <= ClickOne) begin
						timer_d  = 1'b0;
						locked_d = 1'b0;
					end else begin
						locked_d = 1'b1;
					end
				end
			end
		end
	end

	// pack enabled candidates in order
	always_comb begin
		slot[0] = cand_en[0] ? cand[0] : (cand_en[1] ? cand[1] : cand[2]);
		slot[1] = (cand_en[0] && cand_en[1]) ? cand[1] : cand[2];
		slot[2] = cand[2];
		new_cnt = 2'(cand_en[0]) + 2'(cand_en[1]) + 2'(cand_en[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btype_q    <= 1'b0;
			flags_q    <= '0;
			mask_q     <= '0;
			hold_q     <= bdm_pkg::HOLD_TICKS_DEF;
			mc_q       <= bdm_pkg::MC_TICKS_DEF;
			cfgp_q     <= bdm_pkg::CFG_PRESS_DEF;
			silent_q   <= bdm_pkg::SILENT_DEF;
			reported_q <= 1'b0;
			click_q    <= '0;
			locked_q   <= 1'b0;
			elapsed_q  <= '0;
			timer_q    <= 1'b0;
			startup_q  <= '0;
		end else if (cfg_we) begin
			case (bdm_pkg::cfg_reg_t'(cfg_index))
				bdm_pkg::REG_BUTTON_TYPE: btype_q <= cfg_wdata[0];
				bdm_pkg::REG_BUTTON_FLAGS: flags_q <= cfg_wdata[bdm_pkg::FlagsW-1:0];
				bdm_pkg::REG_TRIGGER_MASK: begin
					if (cfg_wdata[bdm_pkg::MaskW-1:0] != mask_q) begin
						timer_q  <= 1'b0;
						click_q  <= '0;
						locked_q <= 1'b0;
					end
					mask_q <= cfg_wdata[bdm_pkg::MaskW-1:0];
				end
				bdm_pkg::REG_HOLD_TICKS:
					hold_q <= (cfg_wdata == '0) ? bdm_pkg::HOLD_TICKS_DEF : cfg_wdata;
				bdm_pkg::REG_MULTICLICK_TICKS:
					mc_q <= (cfg_wdata == '0) ? bdm_pkg::MC_TICKS_DEF : cfg_wdata;
				bdm_pkg::REG_CFG_PRESS_TICKS: cfgp_q <= cfg_wdata;
				bdm_pkg::REG_SILENT_TICKS: silent_q <= cfg_wdata;
				default: ;
			endcase
		end else if (comp_fire) begin
			reported_q <= rep_d;
			click_q    <= click_d;
			locked_q   <= locked_d;
			elapsed_q  <= elapsed_d;
			timer_q    <= timer_d;
			if (startup_q != bdm_pkg::TICK_MAX) startup_q <= startup_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ev_cnt_q <= 2'd0;
			ev_idx_q <= 2'd0;
		end else begin
			if (sample_ch.ready) valid_s1 <= sample_ch.valid;
			if (comp_fire) begin
				ev_cnt_q <= new_cnt;
				ev_idx_q <= 2'd0;
			end else if (take) begin
				if (ev_last) begin
					ev_cnt_q <= 2'd0;
					ev_idx_q <= 2'd0;
				end else begin
					ev_idx_q <= ev_idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.ready) raw_s1 <= sample_ch.raw_level;
		if (comp_fire) begin
			ev_q[0] <= slot[0];
			ev_q[1] <= slot[1];
			ev_q[2] <= slot[2];
		end
	end

	// locking always parks the click counter at zero
	a_locked_clear: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> click_q == '0)
		else $error("locked with nonzero click count");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		ev_cnt_q != 2'd0 |-> ev_idx_q < ev_cnt_q)
		else $error("event index beyond group");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!comp_fire && !cfg_we |=> $stable(reported_q) && $stable(click_q) && $stable(timer_q))
		else $error("click state moved without a tick");

	a_elapsed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_q |=> elapsed_q == $past(elapsed_q) || elapsed_q == '0)
		else $error("elapsed ticks advanced with timer stopped");

endmodule

[sv/bdm_debounce.sv]
module bdm_debounce #(
	parameter int unsigned STABLE_TICKS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             raw,
	input  logic             act_level,
	input  logic             reported,
	output bdm_pkg::db_res_t res
);

	localparam int unsigned CntW = $clog2(STABLE_TICKS + 2);
	localparam logic [CntW-1:0] CntStable = CntW'(STABLE_TICKS);
	localparam logic [CntW-1:0] CntOne    = CntW'(1);
	localparam logic [CntW-1:0] CntTwo    = CntW'(2);

	logic            sample_q, sample_d;
	logic [CntW-1:0] count_q, count_d;

	always_comb begin
		sample_d  = sample_q;
		count_d   = count_q;
		res.level = (raw == act_level);
		res.done  = 1'b0;
		if (count_q == '0) begin
			if (res.level != reported) count_d = CntOne;
		end else if (count_q == CntOne || sample_q != raw) begin
			// start the stable window, or restart it on any bounce
			sample_d = raw;
			count_d  = CntTwo;
		end else if (count_q > CntStable) begin
			count_d  = '0;
			res.done = 1'b1;
		end else begin
			count_d = count_q + CntOne;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= 1'b0;
			count_q  <= '0;
		end else if (step) begin
			sample_q <= sample_d;
			count_q  <= count_d;
		end
	end

endmodule
